>>> rtl/assert_macros.svh
// assertion macros shared by the tracker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ESDT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ESDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/esdt_pkg.sv
// types and constants of the encoder speed and distance tracker
package esdt_pkg;

    localparam int CNT_W      = 16;
    localparam int SPD_W      = 24;
    localparam int Q_W        = 32;
    localparam int REV_W      = 16;
    localparam int PPR_W      = 15;
    localparam int RCP_W      = 25;
    localparam int RCP_LO_W   = 13;
    localparam int TPS_W      = 10;
    localparam int MUL_B_W    = 13;
    localparam int CFG_W      = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 112;
    localparam int DIV_BITS   = 4;

    localparam int SPD_MAX = 8388607;
    localparam int SPD_MIN = -8388608;

    localparam logic [CFG_IDX_W-1:0] CFG_NEGATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PPR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TPS    = 2'd3;

    localparam logic             NEGATE_RST = 1'b0;
    localparam logic [PPR_W-1:0] PPR_RST    = 15'd1024;
    localparam logic [RCP_W-1:0] RCP_RST    = 25'd16384;
    localparam logic [TPS_W-1:0] TPS_RST    = 10'd100;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_NOW,
        S_RESET,
        S_SPEED,
        S_PRIME,
        S_HIST,
        S_DMUL_LO,
        S_DMUL_HI,
        S_DACC,
        S_DFIN,
        S_FMUL_LO,
        S_FMUL_HI,
        S_FACC,
        S_FPREP,
        S_DIV,
        S_FFIN,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_NOW,
        OP_RESET,
        OP_SPEED,
        OP_PRIME,
        OP_HIST,
        OP_DMUL_LO,
        OP_DMUL_HI,
        OP_FMUL_LO,
        OP_FMUL_HI,
        OP_ACC_HI,
        OP_DFIN,
        OP_FPREP,
        OP_DIV,
        OP_FFIN,
        OP_LOAD_OUT
    } t_dp_op;

    typedef struct packed {
        logic   load_in;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic primed;
    } t_dp_stat;

    // cycles of the averaging divider, four quotient bits per cycle
    function automatic int div_cycles(input int depth);
        return (32 + $clog2(depth) + DIV_BITS - 1) / DIV_BITS;
    endfunction

endpackage

>>> rtl/esdt_ram.sv
// generic single write port ram with registered read
module esdt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/esdt_ctrl.sv
// sequencer of the tracker: walks one word through the shared datapath
module esdt_ctrl #(
    parameter int AVERAGE_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output esdt_pkg::t_dp_cmd  o_cmd,
    input  esdt_pkg::t_dp_stat i_stat
);

    localparam int DIV_STEPS = esdt_pkg::div_cycles(AVERAGE_DEPTH);
    localparam int DC_W      = $clog2(DIV_STEPS);

    esdt_pkg::t_state r_state, n_state;
    logic [DC_W-1:0]  r_div_cnt, n_div_cnt;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= esdt_pkg::S_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_div_cnt     = r_div_cnt;
        n_out_valid   = r_out_valid && !i_out_ready;
        o_in_ready    = 1'b0;
        o_cmd.load_in = 1'b0;
        o_cmd.op      = esdt_pkg::OP_NONE;
        unique case (r_state)
            esdt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_in_cmd == esdt_pkg::CMD_RESET) ? esdt_pkg::S_RESET
                                                                : esdt_pkg::S_NOW;
                end
            end
            esdt_pkg::S_NOW: begin
                o_cmd.op = esdt_pkg::OP_NOW;
                n_state  = esdt_pkg::S_SPEED;
            end
            esdt_pkg::S_RESET: begin
                o_cmd.op = esdt_pkg::OP_RESET;
                n_state  = esdt_pkg::S_FMUL_LO;
            end
            esdt_pkg::S_SPEED: begin
                o_cmd.op = esdt_pkg::OP_SPEED;
                n_state  = i_stat.primed ? esdt_pkg::S_HIST : esdt_pkg::S_PRIME;
            end
            esdt_pkg::S_PRIME: begin
                o_cmd.op = esdt_pkg::OP_PRIME;
                n_state  = esdt_pkg::S_HIST;
            end
            esdt_pkg::S_HIST: begin
                o_cmd.op = esdt_pkg::OP_HIST;
                n_state  = esdt_pkg::S_DMUL_LO;
            end
            esdt_pkg::S_DMUL_LO: begin
                o_cmd.op = esdt_pkg::OP_DMUL_LO;
                n_state  = esdt_pkg::S_DMUL_HI;
            end
            esdt_pkg::S_DMUL_HI: begin
                o_cmd.op = esdt_pkg::OP_DMUL_HI;
                n_state  = esdt_pkg::S_DACC;
            end
            esdt_pkg::S_DACC: begin
                o_cmd.op = esdt_pkg::OP_ACC_HI;
                n_state  = esdt_pkg::S_DFIN;
            end
            esdt_pkg::S_DFIN: begin
                o_cmd.op = esdt_pkg::OP_DFIN;
                n_state  = esdt_pkg::S_FMUL_LO;
            end
            esdt_pkg::S_FMUL_LO: begin
                o_cmd.op = esdt_pkg::OP_FMUL_LO;
                n_state  = esdt_pkg::S_FMUL_HI;
            end
            esdt_pkg::S_FMUL_HI: begin
                o_cmd.op = esdt_pkg::OP_FMUL_HI;
                n_state  = esdt_pkg::S_FACC;
            end
            esdt_pkg::S_FACC: begin
                o_cmd.op = esdt_pkg::OP_ACC_HI;
                n_state  = esdt_pkg::S_FPREP;
            end
            esdt_pkg::S_FPREP: begin
                o_cmd.op  = esdt_pkg::OP_FPREP;
                n_div_cnt = '0;
                n_state   = esdt_pkg::S_DIV;
            end
            esdt_pkg::S_DIV: begin
                o_cmd.op  = esdt_pkg::OP_DIV;
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == DC_W'(DIV_STEPS - 1)) begin
                    n_state = esdt_pkg::S_FFIN;
                end
            end
            esdt_pkg::S_FFIN: begin
                o_cmd.op = esdt_pkg::OP_FFIN;
                n_state  = esdt_pkg::S_DONE;
            end
            esdt_pkg::S_DONE: begin
                // hand the word over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = esdt_pkg::OP_LOAD_OUT;
                    n_out_valid = 1'b1;
                    n_state     = esdt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = esdt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/esdt_dp.sv
// datapath of the tracker: registers, shared multiplier, averaging divider
module esdt_dp #(
    parameter int AVERAGE_DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [esdt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [esdt_pkg::CFG_W-1:0]           i_cfg_data,
    input  esdt_pkg::t_dp_cmd                    i_cmd,
    input  logic signed [esdt_pkg::CNT_W-1:0]    i_in_count,
    output esdt_pkg::t_dp_stat                   o_stat,
    output logic [esdt_pkg::OUT_DATA_W-1:0]      o_out_data
);

    localparam int SUM_W     = esdt_pkg::SPD_W + $clog2(AVERAGE_DEPTH);
    localparam int PROD_W    = SUM_W + esdt_pkg::MUL_B_W + 1;
    localparam int ACC_W     = SUM_W + esdt_pkg::RCP_W + 1;
    localparam int IDX_W     = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int RW        = $clog2(AVERAGE_DEPTH) + 1;
    localparam int DIV_STEPS = esdt_pkg::div_cycles(AVERAGE_DEPTH);
    localparam int DIV_PW    = DIV_STEPS * esdt_pkg::DIV_BITS;
    localparam int PAD_W     = esdt_pkg::OUT_DATA_W - 1 - esdt_pkg::SPD_W
                               - 2 * esdt_pkg::Q_W - esdt_pkg::REV_W;

    // configuration
    logic                        r_negate;
    logic [esdt_pkg::PPR_W-1:0]  r_ppr;
    logic [esdt_pkg::RCP_W-1:0]  r_recip;
    logic [esdt_pkg::TPS_W-1:0]  r_tps;

    // tracker state
    logic signed [esdt_pkg::CNT_W-1:0] r_prev;
    logic signed [esdt_pkg::REV_W-1:0] r_revs;
    logic [IDX_W-1:0]                  r_idx;
    logic                              r_primed;
    logic                              r_wrapped;
    logic signed [SUM_W-1:0]           r_sum;

    // per word working registers
    logic signed [esdt_pkg::CNT_W-1:0] r_cnt_in;
    logic signed [esdt_pkg::CNT_W-1:0] r_now;
    logic signed [esdt_pkg::CNT_W-1:0] r_count;
    logic                              r_clear;
    logic signed [esdt_pkg::SPD_W-1:0] r_speed;
    logic signed [esdt_pkg::SPD_W-1:0] r_prime_speed;
    logic signed [PROD_W-1:0]          r_prod;
    logic signed [ACC_W-1:0]           r_acc;
    logic                              r_fneg;
    logic                              r_big;
    logic [DIV_PW-1:0]                 r_dvd;
    logic [RW-1:0]                     r_rem;
    logic signed [esdt_pkg::Q_W-1:0]   r_filt;
    logic signed [esdt_pkg::Q_W-1:0]   r_dist;
    logic [esdt_pkg::OUT_DATA_W-1:0]   r_out;

    logic [esdt_pkg::SPD_W-1:0]          w_ram_rdata;
    logic signed [esdt_pkg::SPD_W-1:0]   w_old;
    logic signed [esdt_pkg::CNT_W-1:0]   w_now;
    logic signed [esdt_pkg::CNT_W:0]     w_neg_in;
    logic signed [esdt_pkg::CNT_W:0]     w_now17;
    logic signed [esdt_pkg::CNT_W:0]     w_ppr17;
    logic signed [esdt_pkg::CNT_W:0]     w_delta;
    logic                                w_fwd;
    logic                                w_back;
    logic signed [SUM_W-1:0]             w_mul_a;
    logic [esdt_pkg::MUL_B_W-1:0]        w_mul_b;
    logic signed [PROD_W-1:0]            w_prod;
    logic [ACC_W-1:0]                    w_amag;
    logic [ACC_W-1:0]                    w_dsh;
    logic [ACC_W-1:0]                    w_m;
    logic                                w_big;
    logic signed [33:0]                  w_dfrac;
    logic signed [33:0]                  w_dsum;
    logic [RW-1:0]                       w_rem;
    logic [DIV_PW-1:0]                   w_dvd;
    logic [32:0]                         w_q;
    logic [32:0]                         w_negq;

    esdt_ram #(
        .WIDTH (esdt_pkg::SPD_W),
        .DEPTH (AVERAGE_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == esdt_pkg::OP_HIST),
        .i_waddr (r_idx),
        .i_wdata (r_speed),
        .i_raddr (r_idx),
        .o_rdata (w_ram_rdata)
    );

    // entries not yet rewritten since priming still hold the first speed
    assign w_old = r_wrapped ? $signed(w_ram_rdata) : r_prime_speed;

    assign w_neg_in = -(esdt_pkg::CNT_W + 1)'(r_cnt_in);
    always_comb begin
        if (!r_negate) begin
            w_now = r_cnt_in;
        end else if (r_cnt_in == 16'sh8000) begin
            w_now = 16'sh7fff;
        end else begin
            w_now = w_neg_in[esdt_pkg::CNT_W-1:0];
        end
    end

    assign w_now17 = (esdt_pkg::CNT_W + 1)'(r_now);
    assign w_ppr17 = $signed({2'b00, r_ppr});
    assign w_delta = w_now17 - (esdt_pkg::CNT_W + 1)'(r_prev);
    assign w_fwd   = (w_now17 >= w_ppr17);
    assign w_back  = (w_now17 <= -w_ppr17);

    // shared multiplier: signed operand times 13 bit unsigned slice
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_cmd.op)
            esdt_pkg::OP_SPEED: begin
                w_mul_a = SUM_W'(w_delta);
                w_mul_b = esdt_pkg::MUL_B_W'(r_tps);
            end
            esdt_pkg::OP_PRIME: begin
                w_mul_a = SUM_W'(r_speed);
                w_mul_b = esdt_pkg::MUL_B_W'(AVERAGE_DEPTH);
            end
            esdt_pkg::OP_DMUL_LO: begin
                w_mul_a = SUM_W'(r_count);
                w_mul_b = r_recip[esdt_pkg::RCP_LO_W-1:0];
            end
            esdt_pkg::OP_DMUL_HI: begin
                w_mul_a = SUM_W'(r_count);
                w_mul_b = esdt_pkg::MUL_B_W'(r_recip[esdt_pkg::RCP_W-1:esdt_pkg::RCP_LO_W]);
            end
            esdt_pkg::OP_FMUL_LO: begin
                w_mul_a = r_sum;
                w_mul_b = r_recip[esdt_pkg::RCP_LO_W-1:0];
            end
            esdt_pkg::OP_FMUL_HI: begin
                w_mul_a = r_sum;
                w_mul_b = esdt_pkg::MUL_B_W'(r_recip[esdt_pkg::RCP_W-1:esdt_pkg::RCP_LO_W]);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * $signed({1'b0, w_mul_b});

    // magnitude rounding, ties away from zero
    assign w_amag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign w_dsh  = (w_amag + ACC_W'(128)) >> 8;
    assign w_m    = (w_amag + ACC_W'(128 * AVERAGE_DEPTH)) >> 8;
    assign w_big  = (w_m[ACC_W-1:32] >= (ACC_W - 32)'(AVERAGE_DEPTH));

    assign w_dfrac = r_acc[ACC_W-1] ? -$signed(w_dsh[33:0]) : $signed(w_dsh[33:0]);
    assign w_dsum  = 34'($signed({r_revs, 16'h0000})) + w_dfrac;

    // restoring division by the window length, four bits a cycle
    always_comb begin : div_steps
        logic [RW:0] v_sh;
        logic        v_qb;
        w_rem = r_rem;
        w_dvd = r_dvd;
        for (int k = 0; k < esdt_pkg::DIV_BITS; k++) begin
            v_sh = {w_rem, w_dvd[DIV_PW-1]};
            v_qb = (v_sh >= (RW + 1)'(AVERAGE_DEPTH));
            if (v_qb) begin
                v_sh = v_sh - (RW + 1)'(AVERAGE_DEPTH);
            end
            w_rem = v_sh[RW-1:0];
            w_dvd = {w_dvd[DIV_PW-2:0], v_qb};
        end
    end

    assign w_q    = r_dvd[32:0];
    assign w_negq = 33'd0 - w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_negate  <= esdt_pkg::NEGATE_RST;
            r_ppr     <= esdt_pkg::PPR_RST;
            r_recip   <= esdt_pkg::RCP_RST;
            r_tps     <= esdt_pkg::TPS_RST;
            r_prev    <= '0;
            r_revs    <= '0;
            r_idx     <= '0;
            r_primed  <= 1'b0;
            r_wrapped <= 1'b0;
            r_sum     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    esdt_pkg::CFG_NEGATE: r_negate <= i_cfg_data[0];
                    esdt_pkg::CFG_PPR:    r_ppr    <= i_cfg_data[esdt_pkg::PPR_W-1:0];
                    esdt_pkg::CFG_RECIP:  r_recip  <= i_cfg_data[esdt_pkg::RCP_W-1:0];
                    esdt_pkg::CFG_TPS:    r_tps    <= i_cfg_data[esdt_pkg::TPS_W-1:0];
                endcase
            end
            unique case (i_cmd.op)
                esdt_pkg::OP_RESET: begin
                    r_prev <= '0;
                    r_revs <= '0;
                end
                esdt_pkg::OP_SPEED: begin
                    if (w_fwd) begin
                        if (r_revs != 16'sh7fff) begin
                            r_revs <= r_revs + 16'sd1;
                        end
                        r_prev <= '0;
                    end else if (w_back) begin
                        if (r_revs != 16'sh8000) begin
                            r_revs <= r_revs - 16'sd1;
                        end
                        r_prev <= '0;
                    end else begin
                        r_prev <= r_now;
                    end
                end
                esdt_pkg::OP_PRIME: begin
                    r_sum    <= SUM_W'(w_prod);
                    r_primed <= 1'b1;
                end
                esdt_pkg::OP_HIST: begin
                    r_sum <= r_sum + SUM_W'(r_speed) - SUM_W'(w_old);
                    if (r_idx == IDX_W'(AVERAGE_DEPTH - 1)) begin
                        r_idx     <= '0;
                        r_wrapped <= 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cnt_in <= i_in_count;
        end
        unique case (i_cmd.op)
            esdt_pkg::OP_NOW: begin
                r_now <= w_now;
            end
            esdt_pkg::OP_RESET: begin
                r_clear <= 1'b1;
                r_speed <= '0;
                r_dist  <= '0;
            end
            esdt_pkg::OP_SPEED: begin
                if (w_prod > PROD_W'(esdt_pkg::SPD_MAX)) begin
                    r_speed <= 24'sh7fffff;
                end else if (w_prod < PROD_W'(esdt_pkg::SPD_MIN)) begin
                    r_speed <= 24'sh800000;
                end else begin
                    r_speed <= w_prod[esdt_pkg::SPD_W-1:0];
                end
                r_clear <= w_fwd || w_back;
                r_count <= (w_fwd || w_back) ? '0 : r_now;
            end
            esdt_pkg::OP_PRIME: begin
                r_prime_speed <= r_speed;
            end
            esdt_pkg::OP_DMUL_LO, esdt_pkg::OP_FMUL_LO: begin
                r_acc <= ACC_W'(w_prod);
            end
            esdt_pkg::OP_DMUL_HI, esdt_pkg::OP_FMUL_HI: begin
                r_prod <= w_prod;
            end
            esdt_pkg::OP_ACC_HI: begin
                r_acc <= r_acc + (ACC_W'(r_prod) <<< esdt_pkg::RCP_LO_W);
            end
            esdt_pkg::OP_DFIN: begin
                if (w_dsum > 34'sh0_7fff_ffff) begin
                    r_dist <= 32'sh7fff_ffff;
                end else if (w_dsum < 34'sh3_8000_0000) begin
                    r_dist <= 32'sh8000_0000;
                end else begin
                    r_dist <= w_dsum[esdt_pkg::Q_W-1:0];
                end
            end
            esdt_pkg::OP_FPREP: begin
                r_fneg <= r_acc[ACC_W-1];
                r_big  <= w_big;
                r_dvd  <= w_m[DIV_PW-1:0];
                r_rem  <= '0;
            end
            esdt_pkg::OP_DIV: begin
                r_dvd <= w_dvd;
                r_rem <= w_rem;
            end
            esdt_pkg::OP_FFIN: begin
                if (!r_primed) begin
                    r_filt <= '0;
                end else if (r_big) begin
                    r_filt <= r_fneg ? 32'sh8000_0000 : 32'sh7fff_ffff;
                end else if (!r_fneg) begin
                    r_filt <= (w_q > 33'h0_7fff_ffff) ? 32'sh7fff_ffff : w_q[31:0];
                end else begin
                    r_filt <= (w_q > 33'h0_8000_0000) ? 32'sh8000_0000 : w_negq[31:0];
                end
            end
            esdt_pkg::OP_LOAD_OUT: begin
                r_out <= {PAD_W'(0), r_dist, r_revs, r_filt, r_speed, r_clear};
            end
            default: begin
            end
        endcase
    end

    assign o_stat.primed = r_primed;
    assign o_out_data    = r_out;

endmodule

>>> rtl/encoder_speed_distance_tracker.sv
// top level of the encoder speed and distance tracker
//
// Input stream: one word per encoder sample tick or distance reset command.
// tuser selects the command (0 sample tick, 1 reset distance), tdata carries
// the signed raw counter reading. Each input word gives exactly one output
// word with the clear request, raw and averaged speed, revolutions and
// distance.
// Registers are written through the plain write port; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Steps of a sample tick: the new count, the speed, on the very first tick a
// pass that preloads the average, the history update, the distance products,
// the average products, and the divider that forms the average. A reset command
// clears distance and revolutions, then runs only the average steps. All work
// runs in turn through the single shared 13 bit slice multiplier and the
// four-bit-per-cycle divider. A word is taken only in idle, one in flight.
// The result sits in an output register, so a new input is accepted while the
// previous result waits; a stalled receiver holds the sequencer only when the
// next result is ready and the register is still full.
// Reset clears the registers to their defaults, the revolution count, the
// previous count and the average; no clearing pass is needed.
`include "assert_macros.svh"

module encoder_speed_distance_tracker #(
    parameter int AVERAGE_DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [esdt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [esdt_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] counter_value
    input  logic [esdt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] command
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] clear_counter, [24:1] speed_pulses, [56:25] filtered_speed,
    // [72:57] revolutions, [104:73] distance, [111:105] zero
    output logic [esdt_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    esdt_pkg::t_dp_cmd  w_cmd;
    esdt_pkg::t_dp_stat w_stat;

    esdt_ctrl #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    esdt_dp #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_in_count  ($signed(s_axis_tdata)),
        .o_stat      (w_stat),
        .o_out_data  (m_axis_tdata)
    );

    // one word in flight: the sequencer is busy right after an accept
    `ESDT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while a word is in flight")
    // a result is loaded only as the sequencer returns to idle
    `ESDT_ASSERT_IMPL(a_idle_on_result, i_clk, i_rst_n, $rose(m_axis_tvalid), s_axis_tready, "result loaded while sequencer busy")
    // the average stays preloaded once primed
    `ESDT_ASSERT_IMPL(a_primed_sticks, i_clk, i_rst_n, 1'b1, !$fell(w_stat.primed), "average lost its preload")

endmodule
